// ===== design/srd_pkg.sv =====
// ----------------------------------------------------------------------------
// srd_pkg
// Shared types, constants and helpers for the stereo reverse delay core.
// ----------------------------------------------------------------------------
package srd_pkg;

   localparam int DELAY_DEPTH = 131072;
   localparam int ADDR_W      = $clog2(DELAY_DEPTH);
   localparam int CNT_W       = ADDR_W + 1;
   localparam int SAMPLE_W    = 24;
   localparam int LEN_W       = 16;
   localparam int GAIN_W      = 16;
   localparam int FB_GAIN_W   = 15;
   localparam int ENV_W       = 16;
   localparam int FADE_W      = 10;
   localparam int PROD_W      = 48;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 16;

   localparam int CHUNK_MIN   = 1024;
   localparam int CHUNK_MAX   = DELAY_DEPTH / 2 - 256;
   localparam int FADE_MIN    = 64;
   localparam int FADE_MAX    = 512;
   localparam int W_MAIN      = 26870;
   localparam int W_TEX       = 12452;
   localparam int LP_ALPHA    = 5898;

   localparam logic [LEN_W-1:0]     CHUNK_LENGTH_RST  = 16'd11536;
   localparam logic [FB_GAIN_W-1:0] FEEDBACK_GAIN_RST = 15'd4557;
   localparam logic [GAIN_W-1:0]    DRY_GAIN_RST      = 16'd27103;
   localparam logic [GAIN_W-1:0]    WET_GAIN_RST      = 16'd18420;

   localparam logic signed [PROD_W-1:0] SAT_HI = PROD_W'((64'sd1 <<< (SAMPLE_W - 1)) - 64'sd1);
   localparam logic signed [PROD_W-1:0] SAT_LO = -SAT_HI - PROD_W'(1);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CHUNK_LENGTH  = 3'd0,
      CSR_FEEDBACK_GAIN = 3'd1,
      CSR_DRY_GAIN      = 3'd2,
      CSR_WET_GAIN      = 3'd3,
      CSR_TEXTURE_MODE  = 3'd4,
      CSR_BYPASS        = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] dry_left;
      logic signed [SAMPLE_W-1:0] dry_right;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] out_left;
      logic signed [SAMPLE_W-1:0] out_right;
   } rsp_type;

   typedef struct packed {
      logic load_in;
      logic setup;
      logic rd_a;
      logic rd_b;
      logic lat_a;
      logic lat_b;
      logic div_start;
      logic env;
      logic tex;
      logic mix;
      logic lp;
      logic fb;
      logic rsp_load;
   } cmd_type;

   typedef struct packed {
      logic bypass;
      logic div_done;
   } status_type;

   function automatic logic signed [SAMPLE_W-1:0] sat_sample(
      input logic signed [PROD_W-1:0] v);
      if (v > SAT_HI) return SAMPLE_W'(SAT_HI);
      if (v < SAT_LO) return SAMPLE_W'(SAT_LO);
      return SAMPLE_W'(v);
   endfunction

endpackage

// ===== design/srd_div.sv =====
// ----------------------------------------------------------------------------
// srd_div
// Serial divider for the fade envelope: quo = floor(num * 32768 / den), num <= den.
// ----------------------------------------------------------------------------
module srd_div import srd_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [FADE_W-1:0] num,
   input  logic [FADE_W-1:0] den,
   output logic [ENV_W-1:0]  quo,
   output logic              done
);

   localparam int STEPS  = 5;
   localparam int CYCLES = (ENV_W - 1) / STEPS;

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [1:0]          cnt_ff, cnt_in;
   logic [FADE_W:0]     rem_ff, rem_in;
   logic [ENV_W-2:0]    frac_ff, frac_in;
   logic                int_ff, int_in;
   logic [FADE_W-1:0]   den_ff, den_in;
   logic [FADE_W:0]     r;
   logic [ENV_W-2:0]    f;

   always_comb begin
      r = rem_ff;
      f = frac_ff;
      for (int k = 0; k < STEPS; k++) begin
         r = {r[FADE_W-1:0], 1'b0};
         if (r >= {1'b0, den_ff}) begin
            r = r - {1'b0, den_ff};
            f = {f[ENV_W-3:0], 1'b1};
         end else begin
            f = {f[ENV_W-3:0], 1'b0};
         end
      end
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = done_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      frac_in = frac_ff;
      int_in  = int_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         done_in = 1'b0;
         cnt_in  = '0;
         den_in  = den;
         int_in  = (num >= den);
         rem_in  = (num >= den) ? {1'b0, num - den} : {1'b0, num};
         frac_in = '0;
      end else if (busy_ff) begin
         rem_in  = r;
         frac_in = f;
         cnt_in  = cnt_ff + 2'd1;
         if (cnt_ff == 2'(CYCLES - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff  <= rem_in;
      frac_ff <= frac_in;
      int_ff  <= int_in;
      den_ff  <= den_in;
   end

   assign quo  = {int_ff, frac_ff};
   assign done = done_ff;

endmodule

// ===== design/srd_dp.sv =====
// ----------------------------------------------------------------------------
// srd_dp
// Datapath: registers, sample stores, envelope, texture mix, lowpass, feedback.
// ----------------------------------------------------------------------------
module srd_dp import srd_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  cmd_type               cmd,
   output status_type            status,
   input  req_type               req_data,
   output rsp_type               rsp_data,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data
);

   logic [LEN_W-1:0]     chunk_length_ff;
   logic [FB_GAIN_W-1:0] feedback_gain_ff;
   logic [GAIN_W-1:0]    dry_gain_ff;
   logic [GAIN_W-1:0]    wet_gain_ff;
   logic                 texture_ff;
   logic                 bypass_ff;

   logic [ADDR_W-1:0]    wp_ff;
   logic [CNT_W-1:0]     captured_ff;
   logic                 active_ff;
   logic [LEN_W-1:0]     active_len_ff;
   logic [ADDR_W-1:0]    chunk_end_ff;
   logic [LEN_W-1:0]     pos_ff;
   logic signed [SAMPLE_W-1:0] lp_l_ff, lp_r_ff;

   req_type              in_ff;
   rsp_type              rsp_ff;
   rsp_type              out_ff;

   logic signed [SAMPLE_W-1:0] delay_left_ff  [DELAY_DEPTH];
   logic signed [SAMPLE_W-1:0] delay_right_ff [DELAY_DEPTH];
   logic signed [SAMPLE_W-1:0] rd_l_ff, rd_r_ff;
   logic                       rd_vld_ff;
   logic signed [SAMPLE_W-1:0] a_l_ff, a_r_ff, b_l_ff, b_r_ff;
   logic signed [SAMPLE_W-1:0] pa_l_ff, pa_r_ff, pb_l_ff, pb_r_ff;
   logic signed [SAMPLE_W-1:0] wl_ff, wr_ff;
   logic signed [SAMPLE_W:0]   diff_l_ff, diff_r_ff;

   logic [LEN_W-1:0]     tgt;
   logic [LEN_W-1:0]     toff;
   logic [ADDR_W-1:0]    ia, ib, rd_addr;
   logic                 rd_en;
   logic                 use_tex;
   logic [LEN_W-1:0]     fade_raw;
   logic [FADE_W-1:0]    fade;
   logic [LEN_W-1:0]     to_end, n_wide;
   logic [FADE_W-1:0]    n;
   logic [ENV_W-1:0]     env;
   logic                 div_done;
   logic [LEN_W-1:0]     pos_next;

   logic signed [PROD_W-1:0] env_s, dry_s, wet_s, fbg_s;
   logic signed [PROD_W-1:0] t_l, t_r, m_l, m_r, f_l, f_r;
   logic signed [SAMPLE_W-1:0] st_l, st_r;

   // chunk window clamp
   always_comb begin
      if (32'(chunk_length_ff) > CHUNK_MAX) tgt = LEN_W'(CHUNK_MAX);
      else if (32'(chunk_length_ff) < CHUNK_MIN) tgt = LEN_W'(CHUNK_MIN);
      else tgt = chunk_length_ff;
      toff = tgt >> 1;
   end

   assign ia      = chunk_end_ff - ADDR_W'(pos_ff);
   assign ib      = ia - ADDR_W'(toff);
   assign rd_en   = cmd.rd_a | cmd.rd_b;
   assign rd_addr = cmd.rd_b ? ib : ia;
   assign use_tex = texture_ff &&
                    (captured_ff >= CNT_W'(active_len_ff) + CNT_W'(toff));

   // fade ramp position
   always_comb begin
      fade_raw = active_len_ff >> 3;
      if (fade_raw < LEN_W'(FADE_MIN)) fade = FADE_W'(FADE_MIN);
      else if (fade_raw > LEN_W'(FADE_MAX)) fade = FADE_W'(FADE_MAX);
      else fade = FADE_W'(fade_raw);
      n_wide = (pos_ff < LEN_W'(fade)) ? pos_ff : LEN_W'(fade);
      to_end = (pos_ff < active_len_ff) ? (active_len_ff - 16'd1 - pos_ff) : '0;
      if (to_end < LEN_W'(fade) && to_end < n_wide) n_wide = to_end;
      n = FADE_W'(n_wide);
   end

   srd_div u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .num   (n),
      .den   (fade),
      .quo   (env),
      .done  (div_done)
   );

   assign env_s = PROD_W'($signed({1'b0, env}));
   assign dry_s = PROD_W'($signed({1'b0, dry_gain_ff}));
   assign wet_s = PROD_W'($signed({1'b0, wet_gain_ff}));
   assign fbg_s = PROD_W'($signed({1'b0, feedback_gain_ff}));

   assign t_l = (PROD_W'(pa_l_ff) * PROD_W'(W_MAIN) + PROD_W'(pb_l_ff) * PROD_W'(W_TEX)) >>> 15;
   assign t_r = (PROD_W'(pa_r_ff) * PROD_W'(W_MAIN) + PROD_W'(pb_r_ff) * PROD_W'(W_TEX)) >>> 15;
   assign m_l = (PROD_W'(in_ff.dry_left) * dry_s + PROD_W'(wl_ff) * wet_s) >>> 15;
   assign m_r = (PROD_W'(in_ff.dry_right) * dry_s + PROD_W'(wr_ff) * wet_s) >>> 15;
   assign f_l = PROD_W'(lp_l_ff) + ((PROD_W'(diff_l_ff) * PROD_W'(LP_ALPHA)) >>> 15);
   assign f_r = PROD_W'(lp_r_ff) + ((PROD_W'(diff_r_ff) * PROD_W'(LP_ALPHA)) >>> 15);
   assign st_l = sat_sample(PROD_W'(in_ff.dry_left) + ((PROD_W'(lp_l_ff) * fbg_s) >>> 15));
   assign st_r = sat_sample(PROD_W'(in_ff.dry_right) + ((PROD_W'(lp_r_ff) * fbg_s) >>> 15));
   assign pos_next = pos_ff + 16'd1;

   // sample stores; entries at or above the fill count read as zero
   always_ff @(posedge clock) begin
      if (cmd.fb && !bypass_ff) begin
         delay_left_ff[wp_ff]  <= st_l;
         delay_right_ff[wp_ff] <= st_r;
      end
      if (rd_en) begin
         rd_l_ff <= delay_left_ff[rd_addr];
         rd_r_ff <= delay_right_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff <= 1'b0;
      end else if (rd_en) begin
         rd_vld_ff <= captured_ff[ADDR_W] || (CNT_W'(rd_addr) < captured_ff);
      end
   end

   // payload pipeline
   always_ff @(posedge clock) begin
      if (cmd.load_in) in_ff <= req_data;
      if (cmd.lat_a) begin
         a_l_ff <= rd_vld_ff ? rd_l_ff : '0;
         a_r_ff <= rd_vld_ff ? rd_r_ff : '0;
      end
      if (cmd.lat_b) begin
         b_l_ff <= rd_vld_ff ? rd_l_ff : '0;
         b_r_ff <= rd_vld_ff ? rd_r_ff : '0;
      end
      if (cmd.env) begin
         pa_l_ff <= SAMPLE_W'((PROD_W'(a_l_ff) * env_s) >>> 15);
         pa_r_ff <= SAMPLE_W'((PROD_W'(a_r_ff) * env_s) >>> 15);
         pb_l_ff <= SAMPLE_W'((PROD_W'(b_l_ff) * env_s) >>> 15);
         pb_r_ff <= SAMPLE_W'((PROD_W'(b_r_ff) * env_s) >>> 15);
      end
      if (cmd.tex) begin
         if (!active_ff) begin
            wl_ff <= '0;
            wr_ff <= '0;
         end else if (use_tex) begin
            wl_ff <= sat_sample(t_l);
            wr_ff <= sat_sample(t_r);
         end else begin
            wl_ff <= pa_l_ff;
            wr_ff <= pa_r_ff;
         end
      end
      if (cmd.mix) begin
         out_ff.out_left  <= sat_sample(m_l);
         out_ff.out_right <= sat_sample(m_r);
         diff_l_ff <= (SAMPLE_W + 1)'(wl_ff) - (SAMPLE_W + 1)'(lp_l_ff);
         diff_r_ff <= (SAMPLE_W + 1)'(wr_ff) - (SAMPLE_W + 1)'(lp_r_ff);
      end
      if (cmd.rsp_load) begin
         if (bypass_ff) begin
            rsp_ff.out_left  <= in_ff.dry_left;
            rsp_ff.out_right <= in_ff.dry_right;
         end else begin
            rsp_ff <= out_ff;
         end
      end
   end

   // configuration and engine state
   always_ff @(posedge clock) begin
      if (reset) begin
         chunk_length_ff  <= CHUNK_LENGTH_RST;
         feedback_gain_ff <= FEEDBACK_GAIN_RST;
         dry_gain_ff      <= DRY_GAIN_RST;
         wet_gain_ff      <= WET_GAIN_RST;
         texture_ff       <= 1'b0;
         bypass_ff        <= 1'b0;
         wp_ff            <= '0;
         captured_ff      <= '0;
         active_ff        <= 1'b0;
         active_len_ff    <= '0;
         chunk_end_ff     <= '0;
         pos_ff           <= '0;
         lp_l_ff          <= '0;
         lp_r_ff          <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_CHUNK_LENGTH:  chunk_length_ff  <= csr_write_data;
            CSR_FEEDBACK_GAIN: feedback_gain_ff <= csr_write_data[FB_GAIN_W-1:0];
            CSR_DRY_GAIN:      dry_gain_ff      <= csr_write_data;
            CSR_WET_GAIN:      wet_gain_ff      <= csr_write_data;
            CSR_TEXTURE_MODE: begin
               if (csr_write_data[0] != texture_ff) begin
                  texture_ff    <= csr_write_data[0];
                  active_ff     <= 1'b0;
                  active_len_ff <= '0;
                  chunk_end_ff  <= '0;
                  pos_ff        <= '0;
                  lp_l_ff       <= '0;
                  lp_r_ff       <= '0;
               end
            end
            CSR_BYPASS: begin
               if (csr_write_data[0] != bypass_ff) begin
                  bypass_ff <= csr_write_data[0];
                  // leaving bypass empties the stores through the fill count
                  if (!csr_write_data[0]) begin
                     wp_ff         <= '0;
                     captured_ff   <= '0;
                     active_ff     <= 1'b0;
                     active_len_ff <= '0;
                     chunk_end_ff  <= '0;
                     pos_ff        <= '0;
                     lp_l_ff       <= '0;
                     lp_r_ff       <= '0;
                  end
               end
            end
            default: ;
         endcase
      end else begin
         if (cmd.setup && !active_ff && captured_ff >= CNT_W'(tgt)) begin
            active_len_ff <= tgt;
            chunk_end_ff  <= wp_ff - ADDR_W'(1);
            pos_ff        <= '0;
            active_ff     <= 1'b1;
         end
         if (cmd.lp) begin
            lp_l_ff <= sat_sample(f_l);
            lp_r_ff <= sat_sample(f_r);
         end
         if (cmd.fb) begin
            wp_ff <= wp_ff + ADDR_W'(1);
            if (!captured_ff[ADDR_W]) captured_ff <= captured_ff + CNT_W'(1);
            if (active_ff) begin
               if (pos_next >= active_len_ff) begin
                  active_ff <= 1'b0;
                  pos_ff    <= '0;
               end else begin
                  pos_ff <= pos_next;
               end
            end
         end
      end
   end

   assign status.bypass   = bypass_ff;
   assign status.div_done = div_done;
   assign rsp_data        = rsp_ff;

endmodule

// ===== design/srd_ctrl.sv =====
// ----------------------------------------------------------------------------
// srd_ctrl
// Sequencer for one sample pair and the result register handshake.
// ----------------------------------------------------------------------------
module srd_ctrl import srd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [11:0] {
      ST_IDLE    = 12'b000000000001,
      ST_SETUP   = 12'b000000000010,
      ST_READ_A  = 12'b000000000100,
      ST_READ_B  = 12'b000000001000,
      ST_LATCH_B = 12'b000000010000,
      ST_DIV     = 12'b000000100000,
      ST_ENV     = 12'b000001000000,
      ST_TEX     = 12'b000010000000,
      ST_MIX     = 12'b000100000000,
      ST_LP      = 12'b001000000000,
      ST_FB      = 12'b010000000000,
      ST_DONE    = 12'b100000000000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_in = 1'b1;
               state_in    = ST_SETUP;
            end
         end
         ST_SETUP: begin
            if (status.bypass) begin
               state_in = ST_DONE;
            end else begin
               cmd.setup = 1'b1;
               state_in  = ST_READ_A;
            end
         end
         ST_READ_A: begin
            cmd.rd_a      = 1'b1;
            cmd.div_start = 1'b1;
            state_in      = ST_READ_B;
         end
         ST_READ_B: begin
            cmd.rd_b  = 1'b1;
            cmd.lat_a = 1'b1;
            state_in  = ST_LATCH_B;
         end
         ST_LATCH_B: begin
            cmd.lat_b = 1'b1;
            state_in  = ST_DIV;
         end
         ST_DIV: begin
            if (status.div_done) state_in = ST_ENV;
         end
         ST_ENV: begin
            cmd.env  = 1'b1;
            state_in = ST_TEX;
         end
         ST_TEX: begin
            cmd.tex  = 1'b1;
            state_in = ST_MIX;
         end
         ST_MIX: begin
            cmd.mix  = 1'b1;
            state_in = ST_LP;
         end
         ST_LP: begin
            cmd.lp   = 1'b1;
            state_in = ST_FB;
         end
         ST_FB: begin
            cmd.fb   = 1'b1;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            // result slot is free or empties on this transfer
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      if (cmd.rsp_load) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   a_load_slot_free: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("result loaded over a pending result");

   a_load_sets_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |=> rsp_valid_ff)
      else $error("result valid not raised after load");

   a_accept_to_setup: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == ST_SETUP))
      else $error("accepted request did not start processing");

   a_no_accept_while_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !cmd.load_in)
      else $error("input loaded while busy");

endmodule

// ===== design/stereo_reverse_delay_core.sv =====
// ----------------------------------------------------------------------------
// stereo_reverse_delay_core
// Stereo reverse delay with fade ramps, texture layer, feedback lowpass and mix.
// ----------------------------------------------------------------------------
// One sample pair is processed at a time: a new pair is taken only after the
// previous one has been loaded into the result register. In bypass the store
// reads and the envelope divider are skipped. The pace is set by the single
// read port of each sample store (two sequential reads per pair) and the serial
// envelope divider, which resolves five quotient bits a cycle. The next pair is
// taken while a finished result still waits in the output register. No clearing
// pass follows reset or leaving bypass: store entries beyond the fill count read
// as zero.
module stereo_reverse_delay_core import srd_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data
);

   cmd_type    cmd;
   status_type status;

   srd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   srd_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_data         (req_data),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

endmodule

// ===== test/stereo_reverse_delay_core_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// stereo_reverse_delay_core_tb
// Drives sample pairs through the reverse delay core under varied flow control
// and register settings, and compares every output pair with a local model.
// ----------------------------------------------------------------------------
module stereo_reverse_delay_core_tb;
   import srd_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int DRAIN_CYCLES   = 40;
   localparam int DMASK          = DELAY_DEPTH - 1;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_IDX = 3'd7;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   req_type               req_data;
   logic                  rsp_valid;
   logic                  rsp_ready;
   rsp_type               rsp_data;
   logic                  csr_write_enable;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_write_data;

   stereo_reverse_delay_core u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // model state
   int unsigned m_chunk_len, m_fb_gain, m_dry_gain, m_wet_gain, m_texture, m_bypass;
   int          store_left  [DELAY_DEPTH];
   int          store_right [DELAY_DEPTH];
   int unsigned wr_pos, fill_count, playing, play_len, play_end, play_pos;
   longint      lp_left, lp_right;

   rsp_type     pending_pairs[$];
   int          error_count;
   int          idle_cycles;
   int          send_idle_pct;
   int          recv_idle_pct;
   int          recv_hold;

   always #10 clock = ~clock;

   function automatic longint clip(longint v);
      if (v > 64'sd8388607) return 64'sd8388607;
      if (v < -64'sd8388608) return -64'sd8388608;
      return v;
   endfunction

   // arithmetic shift by 15 rounding toward minus infinity
   function automatic longint shr15(longint x);
      return x >>> 15;
   endfunction

   function automatic longint fade_gain(int unsigned pos, int unsigned len);
      int unsigned fade;
      int unsigned n;
      int unsigned to_end;
      fade = len / 8;
      if (fade < FADE_MIN) fade = FADE_MIN;
      if (fade > FADE_MAX) fade = FADE_MAX;
      n = (pos < fade) ? pos : fade;
      to_end = (pos < len) ? (len - 1 - pos) : 0;
      if (to_end < fade && to_end < n) n = to_end;
      return longint'((longint'(n) << 15) / fade);
   endfunction

   task automatic clear_playback();
      playing  = 0;
      play_len = 0;
      play_end = 0;
      play_pos = 0;
      lp_left  = 0;
      lp_right = 0;
   endtask

   task automatic clear_engine();
      foreach (store_left[i]) begin
         store_left[i]  = 0;
         store_right[i] = 0;
      end
      wr_pos     = 0;
      fill_count = 0;
      clear_playback();
   endtask

   task automatic model_register_write(input logic [CSR_IDX_W-1:0] idx,
                                       input int unsigned val);
      case (idx)
         CSR_CHUNK_LENGTH:  m_chunk_len = val & 16'hFFFF;
         CSR_FEEDBACK_GAIN: m_fb_gain = val & 15'h7FFF;
         CSR_DRY_GAIN:      m_dry_gain = val & 16'hFFFF;
         CSR_WET_GAIN:      m_wet_gain = val & 16'hFFFF;
         CSR_TEXTURE_MODE: begin
            if ((val & 1) != m_texture) begin
               m_texture = val & 1;
               clear_playback();
            end
         end
         CSR_BYPASS: begin
            if ((val & 1) != m_bypass) begin
               m_bypass = val & 1;
               if (m_bypass == 0) clear_engine();
            end
         end
         default: ;
      endcase
   endtask

   function automatic rsp_type mix_pair(input req_type pair);
      longint      dl, dr, wl, wr, env, pl, pr, sl, sr;
      int unsigned tgt, toff, ia, ib;
      rsp_type     res;
      dl = pair.dry_left;
      dr = pair.dry_right;
      wl = 0;
      wr = 0;
      if (m_bypass) begin
         res.out_left  = pair.dry_left;
         res.out_right = pair.dry_right;
         return res;
      end
      tgt = m_chunk_len;
      if (tgt > CHUNK_MAX) tgt = CHUNK_MAX;
      if (tgt < CHUNK_MIN) tgt = CHUNK_MIN;
      toff = tgt / 2;
      if (!playing && fill_count >= tgt) begin
         play_len = tgt;
         play_end = (wr_pos - 1) & DMASK;
         play_pos = 0;
         playing  = 1;
      end
      if (playing) begin
         env = fade_gain(play_pos, play_len);
         ia  = (play_end - play_pos) & DMASK;
         pl  = shr15(longint'(store_left[ia]) * env);
         pr  = shr15(longint'(store_right[ia]) * env);
         wl  = pl;
         wr  = pr;
         if (m_texture && fill_count >= play_len + toff) begin
            ib = (play_end - play_pos - toff) & DMASK;
            sl = shr15(longint'(store_left[ib]) * env);
            sr = shr15(longint'(store_right[ib]) * env);
            wl = shr15(pl * W_MAIN + sl * W_TEX);
            wr = shr15(pr * W_MAIN + sr * W_TEX);
         end
         play_pos++;
         if (play_pos >= play_len) begin
            playing  = 0;
            play_pos = 0;
         end
      end
      wl = clip(wl);
      wr = clip(wr);
      res.out_left  = SAMPLE_W'(clip(shr15(dl * m_dry_gain + wl * m_wet_gain)));
      res.out_right = SAMPLE_W'(clip(shr15(dr * m_dry_gain + wr * m_wet_gain)));
      lp_left  = clip(lp_left + shr15(LP_ALPHA * (wl - lp_left)));
      lp_right = clip(lp_right + shr15(LP_ALPHA * (wr - lp_right)));
      store_left[wr_pos & DMASK]  = int'(clip(dl + shr15(lp_left * m_fb_gain)));
      store_right[wr_pos & DMASK] = int'(clip(dr + shr15(lp_right * m_fb_gain)));
      wr_pos = (wr_pos + 1) & DMASK;
      if (fill_count < DELAY_DEPTH) fill_count++;
      return res;
   endfunction

   // one transfer in; the model is updated at the accepting edge
   task automatic send_pair(input req_type pair, input logic check_typed,
                            input rsp_type typed_rsp);
      rsp_type predicted;
      while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= pair;
      do @(posedge clock); while (!req_ready);
      predicted = mix_pair(pair);
      if (check_typed && predicted != typed_rsp)
         predicted = typed_rsp;
      pending_pairs.push_back(predicted);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_pairs.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx, input int unsigned val);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= CSR_DATA_W'(val);
      @(posedge clock);
      csr_write_enable <= 1'b0;
      model_register_write(idx, val);
      @(posedge clock);
   endtask

   function automatic req_type random_pair();
      req_type p;
      case ($urandom_range(9))
         0:       p.dry_left = 24'h7FFFFF;
         1:       p.dry_left = 24'h800000;
         default: p.dry_left = SAMPLE_W'($urandom);
      endcase
      case ($urandom_range(9))
         0:       p.dry_right = 24'h7FFFFF;
         1:       p.dry_right = 24'h800000;
         default: p.dry_right = SAMPLE_W'($urandom);
      endcase
      return p;
   endfunction

   task automatic random_phase(input int count);
      repeat (count) send_pair(random_pair(), 1'b0, '0);
   endtask

   // receiver side
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (recv_hold > 0) begin
         recv_hold <= recv_hold - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= !(recv_idle_pct > 0 && $urandom_range(99) < recv_idle_pct);
      end
   end

   // output check
   always @(posedge clock) begin
      rsp_type wanted;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_pairs.size() == 0) begin
            $error("output transfer with nothing pending");
            error_count++;
         end else begin
            wanted = pending_pairs.pop_front();
            if (rsp_data.out_left !== wanted.out_left) begin
               $error("out_left expected %0d actual %0d", wanted.out_left,
                      rsp_data.out_left);
               error_count++;
            end
            if (rsp_data.out_right !== wanted.out_right) begin
               $error("out_right expected %0d actual %0d", wanted.out_right,
                      rsp_data.out_right);
               error_count++;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   typedef struct {
      int      left;
      int      right;
      logic    typed;
      int      out_l;
      int      out_r;
   } stim_row_type;

   // after reset the stores are empty, so output is the dry leg alone
   // 27103/32768 applied to full scale and to the extremes
   stim_row_type directed_rows[] = '{
      '{0,         0,         1'b1, 0,        0},
      '{8388607,   -8388608,  1'b1, 6938367,  -6938368},
      '{-8388608,  8388607,   1'b1, -6938368, 6938367},
      '{1,         -1,        1'b1, 0,        -1},
      '{4194304,   -4194304,  1'b0, 0,        0},
      '{-1,        1,         1'b0, 0,        0},
      '{123456,    -654321,   1'b0, 0,        0},
      '{8388607,   8388607,   1'b0, 0,        0}
   };

   initial begin
      req_type pair;
      rsp_type typed_rsp;
      clock            = 1'b0;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_data         = '0;
      csr_write_enable = 1'b0;
      csr_index        = '0;
      csr_write_data   = '0;
      error_count      = 0;
      idle_cycles      = 0;
      send_idle_pct    = 0;
      recv_idle_pct    = 0;
      recv_hold        = 0;
      m_chunk_len = CHUNK_LENGTH_RST;
      m_fb_gain   = FEEDBACK_GAIN_RST;
      m_dry_gain  = DRY_GAIN_RST;
      m_wet_gain  = WET_GAIN_RST;
      m_texture   = 0;
      m_bypass    = 0;
      clear_engine();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         pair.dry_left   = SAMPLE_W'(directed_rows[i].left);
         pair.dry_right  = SAMPLE_W'(directed_rows[i].right);
         typed_rsp.out_left  = SAMPLE_W'(directed_rows[i].out_l);
         typed_rsp.out_right = SAMPLE_W'(directed_rows[i].out_r);
         send_pair(pair, directed_rows[i].typed, typed_rsp);
      end
      drain();

      // bypass passes input through; leaving it clears the stores, playback and lowpass state
      write_register(CSR_BYPASS, 1);
      random_phase(4);
      drain();
      write_register(CSR_TEXTURE_MODE, 1);
      random_phase(2);
      drain();
      write_register(CSR_TEXTURE_MODE, 1);
      random_phase(2);
      drain();
      write_register(CSR_BYPASS, 0);
      write_register(CSR_BYPASS, 0);

      // shortest chunk, texture on, high feedback, full gains
      write_register(CSR_CHUNK_LENGTH, 0);
      write_register(CSR_FEEDBACK_GAIN, 31621);
      write_register(CSR_DRY_GAIN, 32768);
      write_register(CSR_WET_GAIN, 32768);
      write_register(CSR_UNUSED_IDX, 16'hFFFF);
      random_phase(400);

      // long stall on the output while input keeps coming
      recv_hold = 300;
      random_phase(60);
      drain();

      send_idle_pct = 64;
      write_register(CSR_TEXTURE_MODE, 0);
      write_register(CSR_CHUNK_LENGTH, 1500);
      write_register(CSR_FEEDBACK_GAIN, 0);
      write_register(CSR_DRY_GAIN, 0);
      random_phase(350);
      drain();

      send_idle_pct = 0;
      recv_idle_pct = 64;
      write_register(CSR_TEXTURE_MODE, 1);
      write_register(CSR_DRY_GAIN, 16384);
      write_register(CSR_WET_GAIN, 0);
      write_register(CSR_FEEDBACK_GAIN, 16000);
      random_phase(350);
      drain();

      send_idle_pct = 38;
      recv_idle_pct = 38;
      write_register(CSR_WET_GAIN, 30000);
      write_register(CSR_CHUNK_LENGTH, 16'hFFFF);
      random_phase(300);
      drain();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_register(CSR_CHUNK_LENGTH, 1024);
      write_register(CSR_FEEDBACK_GAIN, 31621);
      random_phase(400);
      drain();

      if (error_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

// ===== filelist.f =====
design/srd_pkg.sv
design/srd_div.sv
design/srd_dp.sv
design/srd_ctrl.sv
design/stereo_reverse_delay_core.sv
test/stereo_reverse_delay_core_tb.sv
